// ===== rtl/core/pdq_pkg.sv =====
// Package for the priority deque task queue: defaults, request and status codes, cell control.
`default_nettype none

package pdq_pkg;

  // Default sizes of the queue.
  localparam int unsigned PdqDepth   = 16;
  localparam int unsigned PdqTagBits = 16;

  // Port widths that are fixed by the request and result formats.
  localparam int unsigned TagPortW = 16;
  localparam int unsigned PosW     = 4;
  localparam int unsigned OccW     = 5;
  localparam int unsigned StatusW  = 2;

  // Request codes.
  localparam logic ReqAdd      = 1'b0;
  localparam logic ReqComplete = 1'b1;

  // Status codes.
  localparam logic [StatusW-1:0] StatusOk     = 2'd0;
  localparam logic [StatusW-1:0] StatusFull   = 2'd1;
  localparam logic [StatusW-1:0] StatusBadPos = 2'd2;

  // Per-cell update command, decoded once per cell by the top level.
  typedef struct packed {
    logic load_new;   // take the incoming task
    logic take_prev;  // shift back: take the entry of the cell nearer the head
    logic take_next;  // close a gap: take the entry of the cell nearer the tail
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdq_cell.sv =====
// One slot of the task deque: holds a tag and urgent bit and trades entries with its neighbors.
`default_nettype none

module pdq_cell #(
  parameter int unsigned DataW = pdq_pkg::PdqTagBits + 1
) (
  input  wire                    clk_i,
  input  wire pdq_pkg::cell_ctrl_t ctrl_i,
  input  wire  [DataW-1:0]       new_data_i,
  input  wire  [DataW-1:0]       prev_data_i,
  input  wire  [DataW-1:0]       next_data_i,
  output logic [DataW-1:0]       data_o
);

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;

  // A new task has priority; a slot never gets two commands in the same cycle otherwise.
  always_comb begin
    if (ctrl_i.load_new) begin
      data_d = new_data_i;
    end else if (ctrl_i.take_prev) begin
      data_d = prev_data_i;
    end else if (ctrl_i.take_next) begin
      data_d = next_data_i;
    end else begin
      data_d = data_q;
    end
  end

  // Slot contents are undefined until written, so they carry no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/priority_deque_task_queue.sv =====
// Top level of the priority deque task queue: a row of slot cells with count and result logic.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         start & !busy              req_type_i, task_tag_i, urgent_i, position_i
//   result    out        result_valid_o (1 cycle)   done_tag_o, done_urgent_o, status_o, occupancy_o
//
// Each request moves all slots by at most one place in parallel, and the result is shown
// in the cycle after the transfer. A new request can follow every cycle, so busy stays low.
// Reset clears the count and the result strobe; slot contents are left as they are.
// The receiver cannot stall, so nothing else holds the block off.
`default_nettype none

module priority_deque_task_queue #(
  parameter int unsigned QUEUE_DEPTH = pdq_pkg::PdqDepth,
  parameter int unsigned TAG_BITS    = pdq_pkg::PdqTagBits
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire                            req_type_i,
  input  wire  [pdq_pkg::TagPortW-1:0]   task_tag_i,
  input  wire                            urgent_i,
  input  wire  [pdq_pkg::PosW-1:0]       position_i,
  output logic                           result_valid_o,
  output logic [pdq_pkg::TagPortW-1:0]   done_tag_o,
  output logic                           done_urgent_o,
  output logic [pdq_pkg::StatusW-1:0]    status_o,
  output logic [pdq_pkg::OccW-1:0]       occupancy_o
);

  localparam int unsigned DataW = TAG_BITS + 1;
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > pdq_pkg::PosW) ? CntW : pdq_pkg::PosW;

  logic                 accept;
  logic                 full;
  logic                 add_ok;
  logic                 rm_ok;
  logic [CmpW-1:0]      pos_ext;
  logic [CmpW-1:0]      cnt_ext;
  logic [DataW-1:0]     new_data;
  logic [DataW-1:0]     sel_data;
  logic [DataW-1:0]     cell_data [QUEUE_DEPTH];
  pdq_pkg::cell_ctrl_t  cell_ctrl [QUEUE_DEPTH];

  logic [CntW-1:0]              count_q, count_d;
  logic                         result_valid_q;
  logic [pdq_pkg::TagPortW-1:0] done_tag_q, done_tag_d;
  logic                         done_urgent_q, done_urgent_d;
  logic [pdq_pkg::StatusW-1:0]  status_q, status_d;
  logic [pdq_pkg::OccW-1:0]     occupancy_q;

  // Every request finishes in the cycle of its transfer.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Request decode.
  assign full     = (count_q == CntW'(QUEUE_DEPTH));
  assign pos_ext  = CmpW'(position_i);
  assign cnt_ext  = CmpW'(count_q);
  assign add_ok   = accept & (req_type_i == pdq_pkg::ReqAdd) & ~full;
  assign rm_ok    = accept & (req_type_i == pdq_pkg::ReqComplete) & (pos_ext < cnt_ext);
  assign new_data = {urgent_i, TAG_BITS'(task_tag_i)};

  // Row of slot cells, each with its own decoded command.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [DataW-1:0] prev_data;
    logic [DataW-1:0] next_data;

    if (g == 0) begin : g_head
      assign prev_data = new_data;
    end else begin : g_body
      assign prev_data = cell_data[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_data = cell_data[g];
    end else begin : g_inner
      assign next_data = cell_data[g+1];
    end

    assign cell_ctrl[g].load_new  = add_ok & ((urgent_i & (g == 0)) |
                                              (~urgent_i & (cnt_ext == CmpW'(g))));
    assign cell_ctrl[g].take_prev = add_ok & urgent_i & (g != 0);
    assign cell_ctrl[g].take_next = rm_ok & (CmpW'(g) >= pos_ext) & (g != QUEUE_DEPTH - 1);

    pdq_cell #(
      .DataW (DataW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .new_data_i  (new_data),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (cell_data[g])
    );
  end

  // Pick the slot named by the position: each cell gated by its own match, then ORed.
  always_comb begin
    sel_data = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      sel_data = sel_data | (cell_data[k] & {DataW{pos_ext == CmpW'(k)}});
    end
  end

  // Result fields and the next count.
  always_comb begin
    count_d       = count_q;
    done_tag_d    = '0;
    done_urgent_d = 1'b0;
    status_d      = pdq_pkg::StatusOk;
    if (req_type_i == pdq_pkg::ReqAdd) begin
      if (full) begin
        status_d = pdq_pkg::StatusFull;
      end else if (accept) begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (!rm_ok) begin
        status_d = pdq_pkg::StatusBadPos;
      end else begin
        count_d       = count_q - CntW'(1);
        done_tag_d    = pdq_pkg::TagPortW'(sel_data[TAG_BITS-1:0]);
        done_urgent_d = sel_data[TAG_BITS];
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_tag_q    <= done_tag_d;
      done_urgent_q <= done_urgent_d;
      status_q      <= status_d;
      occupancy_q   <= pdq_pkg::OccW'(count_d);
    end
  end

  assign result_valid_o = result_valid_q;
  assign done_tag_o     = done_tag_q;
  assign done_urgent_o  = done_urgent_q;
  assign status_o       = status_q;
  assign occupancy_o    = occupancy_q;

`ifndef SYNTH
  // The count never runs past the number of slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("task count exceeds queue depth");

  // A rejected request leaves the count where it was.
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && (status_q != pdq_pkg::StatusOk)) |-> $stable(count_q))
    else $error("rejected request changed the task count");

  // A completed task reduces the registered count by one.
  a_complete_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rm_ok |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("complete did not remove one task");

  // Every transfer gives a result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_q)
    else $error("request transfer without a result");
`endif

endmodule

`default_nettype wire
